// ===== rtl/core/rgpc_pkg.sv =====
`timescale 1ns / 1ps
package rgpc_pkg;

  // Default field widths
  localparam int unsigned TAG_BITS_DEF    = 16;
  localparam int unsigned RADIUS_BITS_DEF = 18;
  localparam int unsigned HEIGHT_W        = 16;

  // Config port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Config reset values
  localparam int unsigned LOCAL_TAN_RST     = 5793;
  localparam int unsigned GENERAL_TAN_RST   = 2293;
  localparam int unsigned MIN_HEIGHT_RST    = 50;
  localparam int unsigned RING_SPACING_RST  = 100;
  localparam int unsigned RECLASS_GAP_RST   = 200;
  localparam int          MOUNT_HEIGHT_RST  = 1800;

  // Previous point height after reset: ground plane under the sensor
  localparam logic signed [HEIGHT_W:0] LAST_HEIGHT_RST = (HEIGHT_W+1)'(-MOUNT_HEIGHT_RST);

  // Decoupling queue between front and back
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_TAN     = 3'd0,
    REG_GENERAL_TAN   = 3'd1,
    REG_MIN_HEIGHT    = 3'd2,
    REG_RING_SPACING  = 3'd3,
    REG_RECLASS_GAP   = 3'd4,
    REG_MOUNT_HEIGHT  = 3'd5
  } rgpc_reg_e;

  typedef struct packed {
    logic [15:0] local_tan;
    logic [15:0] general_tan;
    logic [15:0] min_height;
    logic [17:0] ring_spacing;
    logic [17:0] reclass_gap;
    logic [14:0] mount_height;
  } cfg_t;

  // Per-point test results handed from front to back
  typedef struct packed {
    logic ray_start;
    logic local_ok;
    logic general_ok;
    logic reclass_ok;
  } cls_t;

endpackage

// ===== rtl/core/rgpc_front.sv =====
`timescale 1ns / 1ps
module rgpc_front #(
  parameter int unsigned TAG_BITS    = rgpc_pkg::TAG_BITS_DEF,
  parameter int unsigned RADIUS_BITS = rgpc_pkg::RADIUS_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rgpc_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [RADIUS_BITS-1:0]             radius_i,
  input  logic signed [rgpc_pkg::HEIGHT_W-1:0] height_i,
  input  logic                               ray_start_i,
  input  logic [TAG_BITS-1:0]                point_tag_i,
  input  logic [rgpc_pkg::FIFO_CNT_W-1:0]    fifo_cnt_i,
  output logic [1:0]                         inflight_o,
  output logic                               push_o,
  output logic [TAG_BITS-1:0]                push_tag_o,
  output rgpc_pkg::cls_t                     push_cls_o
);

  localparam int unsigned HW   = rgpc_pkg::HEIGHT_W;
  localparam int unsigned SW   = RADIUS_BITS + 1;            // radial step
  localparam int unsigned PW   = RADIUS_BITS + 18;           // local tan * step
  localparam int unsigned TW   = (PW > 33) ? PW : 33;        // threshold incl. floor
  localparam int unsigned LW   = TW - 16;                    // threshold in mm
  localparam int unsigned CW   = ((LW > HW + 2) ? LW : HW + 2) + 1;
  localparam int unsigned GW   = RADIUS_BITS + 16;           // general tan * radius
  localparam int unsigned CMPW = ((RADIUS_BITS > 18) ? RADIUS_BITS : 18) + 2;
  localparam int unsigned UW   = rgpc_pkg::FIFO_CNT_W + 1;

  // diff*65536 within +-limit  <=>  diff within +-floor(limit/65536)
  function automatic logic in_win(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] lim);
    return (x <= lim) && (-x <= lim);
  endfunction

  logic                        accept;
  logic [RADIUS_BITS-1:0]      lr_eff;
  logic signed [HW:0]          lh_eff;
  logic signed [SW-1:0]        step_d;
  logic signed [HW+1:0]        diff_d;
  logic signed [HW+1:0]        hgnd_d;
  logic [UW-1:0]               used;

  logic [RADIUS_BITS-1:0]      last_radius_q;
  logic signed [HW:0]          last_height_q;

  logic                        s1_v_q;
  logic signed [SW-1:0]        s1_step_q;
  logic signed [HW+1:0]        s1_diff_q;
  logic signed [HW+1:0]        s1_hgnd_q;
  logic [RADIUS_BITS-1:0]      s1_radius_q;
  logic                        s1_start_q;
  logic [TAG_BITS-1:0]         s1_tag_q;

  logic signed [PW-1:0]        lprod;
  logic [GW-1:0]               gprod;
  logic signed [CMPW-1:0]      step_c;
  logic                        gt_ring;
  logic                        gt_gap;

  logic                        s2_v_q;
  logic signed [PW-1:0]        s2_lprod_q;
  logic [GW-1:0]               s2_gprod_q;
  logic                        s2_gt_ring_q;
  logic                        s2_gt_gap_q;
  logic signed [HW+1:0]        s2_diff_q;
  logic signed [HW+1:0]        s2_hgnd_q;
  logic                        s2_start_q;
  logic [TAG_BITS-1:0]         s2_tag_q;

  logic signed [TW-1:0]        lthr_w;
  logic signed [TW-1:0]        floor_w;
  logic signed [TW-1:0]        lthr;
  logic signed [CW-1:0]        lim_loc;
  logic signed [CW-1:0]        lim_gen;
  logic signed [CW-1:0]        diff_c;
  logic signed [CW-1:0]        hgnd_c;

  // Credit check: queue entries plus words in flight never exceed queue depth
  assign used = UW'(fifo_cnt_i) + UW'(s1_v_q) + UW'(s2_v_q);
  assign in_stall_o = (used >= UW'(rgpc_pkg::FIFO_DEPTH));
  assign accept = in_valid_i && !in_stall_o;
  assign inflight_o = 2'(s1_v_q) + 2'(s2_v_q);

  // Stage 0: previous point (reset at ray start), step and height differences
  assign lr_eff = ray_start_i ? '0 : last_radius_q;
  assign lh_eff = ray_start_i ? -$signed({2'b00, cfg_i.mount_height}) : last_height_q;
  assign step_d = $signed({1'b0, radius_i}) - $signed({1'b0, lr_eff});
  assign diff_d = (HW+2)'(height_i) - (HW+2)'(lh_eff);
  assign hgnd_d = (HW+2)'(height_i) + $signed({3'b000, cfg_i.mount_height});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_radius_q <= '0;
      last_height_q <= rgpc_pkg::LAST_HEIGHT_RST;
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      if (accept) begin
        last_radius_q <= radius_i;
        last_height_q <= (HW+1)'(height_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_step_q   <= step_d;
    s1_diff_q   <= diff_d;
    s1_hgnd_q   <= hgnd_d;
    s1_radius_q <= radius_i;
    s1_start_q  <= ray_start_i;
    s1_tag_q    <= point_tag_i;
  end

  // Stage 1: slope products and gap compares
  assign lprod   = PW'($signed({1'b0, cfg_i.local_tan}) * s1_step_q);
  assign gprod   = GW'(cfg_i.general_tan * s1_radius_q);
  assign step_c  = CMPW'(s1_step_q);
  assign gt_ring = step_c > $signed(CMPW'({1'b0, cfg_i.ring_spacing}));
  assign gt_gap  = step_c > $signed(CMPW'({1'b0, cfg_i.reclass_gap}));

  always_ff @(posedge clk_i) begin
    s2_lprod_q   <= lprod;
    s2_gprod_q   <= gprod;
    s2_gt_ring_q <= gt_ring;
    s2_gt_gap_q  <= gt_gap;
    s2_diff_q    <= s1_diff_q;
    s2_hgnd_q    <= s1_hgnd_q;
    s2_start_q   <= s1_start_q;
    s2_tag_q     <= s1_tag_q;
  end

  // Stage 2: floor on the local threshold, window tests, push to queue
  assign lthr_w  = TW'(s2_lprod_q);
  assign floor_w = TW'($signed({1'b0, cfg_i.min_height, 16'h0000}));
  assign lthr    = (s2_gt_ring_q && (lthr_w < floor_w)) ? floor_w : lthr_w;
  assign lim_loc = CW'($signed(lthr[TW-1:16]));
  assign lim_gen = CW'($signed({1'b0, s2_gprod_q[GW-1:16]}));
  assign diff_c  = CW'(s2_diff_q);
  assign hgnd_c  = CW'(s2_hgnd_q);

  assign push_o                = s2_v_q;
  assign push_tag_o            = s2_tag_q;
  assign push_cls_o.ray_start  = s2_start_q;
  assign push_cls_o.local_ok   = in_win(diff_c, lim_loc);
  assign push_cls_o.general_ok = in_win(hgnd_c, lim_gen);
  assign push_cls_o.reclass_ok = s2_gt_gap_q && in_win(hgnd_c, lim_loc);

endmodule

// ===== rtl/core/rgpc_fifo.sv =====
`timescale 1ns / 1ps
module rgpc_fifo #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = rgpc_pkg::FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] cnt_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/rgpc_back.sv =====
`timescale 1ns / 1ps
module rgpc_back #(
  parameter int unsigned TAG_BITS = rgpc_pkg::TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  rgpc_pkg::cls_t      cls_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TAG_BITS-1:0] point_tag_res_o,
  output logic                is_ground_o
);

  logic                out_valid_q;
  logic                last_ground_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                ground_q;
  logic                lg;
  logic                ground;

  // Take a word when the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  // Ground decision: the only part that depends on the previous result
  assign lg     = cls_i.ray_start ? 1'b0 : last_ground_q;
  assign ground = cls_i.local_ok ? (lg || cls_i.general_ok) : cls_i.reclass_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      last_ground_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q   <= 1'b1;
        last_ground_q <= ground;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_q    <= tag_i;
      ground_q <= ground;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign point_tag_res_o = tag_q;
  assign is_ground_o     = ground_q;

endmodule

// ===== rtl/core/ray_ground_point_classifier_top.sv =====
`timescale 1ns / 1ps
// From accept to out_valid_o a word passes two front stages, the queue and the output reg.
// Throughput: one word per cycle when not stalled; products and window tests are pipelined
// in the front, and only the one-bit ground recurrence sits in the back stage.
// in_stall_o rises when the 8-entry queue plus the two front stages hold 8 words.
// Reset (async, active low) empties pipeline, queue and output, sets config to defaults
// and the previous point to radius 0, height -1800 mm, not ground.
module ray_ground_point_classifier_top #(
  parameter int unsigned TAG_BITS    = rgpc_pkg::TAG_BITS_DEF,
  parameter int unsigned RADIUS_BITS = rgpc_pkg::RADIUS_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rgpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rgpc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [RADIUS_BITS-1:0]               radius_i,
  input  logic signed [rgpc_pkg::HEIGHT_W-1:0] height_i,
  input  logic                                 ray_start_i,
  input  logic [TAG_BITS-1:0]                  point_tag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [TAG_BITS-1:0]                  point_tag_res_o,
  output logic                                 is_ground_o
);

  localparam int unsigned CLS_W  = $bits(rgpc_pkg::cls_t);
  localparam int unsigned WORD_W = TAG_BITS + CLS_W;
  localparam int unsigned CNT_W  = rgpc_pkg::FIFO_CNT_W;

  rgpc_pkg::cfg_t        cfg_q;
  logic [CNT_W-1:0]      fifo_cnt;
  logic [1:0]            inflight;
  logic                  fifo_push;
  logic [TAG_BITS-1:0]   push_tag;
  rgpc_pkg::cls_t        push_cls;
  logic                  fifo_pop;
  logic                  fifo_empty;
  logic [WORD_W-1:0]     fifo_rdata;
  rgpc_pkg::cls_t        pop_cls;
  logic [TAG_BITS-1:0]   pop_tag;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_tan     <= 16'(rgpc_pkg::LOCAL_TAN_RST);
      cfg_q.general_tan   <= 16'(rgpc_pkg::GENERAL_TAN_RST);
      cfg_q.min_height    <= 16'(rgpc_pkg::MIN_HEIGHT_RST);
      cfg_q.ring_spacing  <= 18'(rgpc_pkg::RING_SPACING_RST);
      cfg_q.reclass_gap   <= 18'(rgpc_pkg::RECLASS_GAP_RST);
      cfg_q.mount_height  <= 15'(rgpc_pkg::MOUNT_HEIGHT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgpc_pkg::REG_LOCAL_TAN:     cfg_q.local_tan     <= cfg_wdata_i[15:0];
        rgpc_pkg::REG_GENERAL_TAN:   cfg_q.general_tan   <= cfg_wdata_i[15:0];
        rgpc_pkg::REG_MIN_HEIGHT:    cfg_q.min_height    <= cfg_wdata_i[15:0];
        rgpc_pkg::REG_RING_SPACING:  cfg_q.ring_spacing  <= cfg_wdata_i[17:0];
        rgpc_pkg::REG_RECLASS_GAP:   cfg_q.reclass_gap   <= cfg_wdata_i[17:0];
        rgpc_pkg::REG_MOUNT_HEIGHT:  cfg_q.mount_height  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Front: accept, window tests
  rgpc_front #(
    .TAG_BITS    (TAG_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .radius_i    (radius_i),
    .height_i    (height_i),
    .ray_start_i (ray_start_i),
    .point_tag_i (point_tag_i),
    .fifo_cnt_i  (fifo_cnt),
    .inflight_o  (inflight),
    .push_o      (fifo_push),
    .push_tag_o  (push_tag),
    .push_cls_o  (push_cls)
  );

  // Decoupling queue
  rgpc_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (rgpc_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i ({push_tag, push_cls}),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .empty_o (fifo_empty),
    .cnt_o   (fifo_cnt)
  );

  assign pop_tag = fifo_rdata[WORD_W-1:CLS_W];
  assign pop_cls = fifo_rdata[CLS_W-1:0];

  // Back: ground recurrence and output register
  rgpc_back #(
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (fifo_empty),
    .tag_i           (pop_tag),
    .cls_i           (pop_cls),
    .pop_o           (fifo_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .point_tag_res_o (point_tag_res_o),
    .is_ground_o     (is_ground_o)
  );

  // Credit scheme keeps words in flight within queue space
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+1)'(fifo_cnt) + (CNT_W+1)'(inflight)) <= (CNT_W+1)'(rgpc_pkg::FIFO_DEPTH))
    else $error("front words in flight exceed queue space");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt != CNT_W'(rgpc_pkg::FIFO_DEPTH)) || fifo_pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> (fifo_cnt != '0))
    else $error("pop from empty queue");

endmodule
